>>> sv/sorted_key_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted key priority queue assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_KEY_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SKPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skpq check failed");
// next-cycle implication
`define SKPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skpq check failed");
`else
`define SKPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SKPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/skpq_pkg.sv
// ----------------------------------------------------------------------------
// skpq_pkg
// shared types and constants of the sorted key priority queue
// ----------------------------------------------------------------------------
package skpq_pkg;

   localparam int DEPTH      = 16;
   localparam int ID_BITS    = 8;
   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_POP    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // one slot of the chain
   typedef struct packed {
      logic                used;
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  id;
   } entry_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                do_insert;
      logic                do_remove;
      logic                match_en;
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  id;
   } op_type;

   localparam entry_type ENTRY_EMPTY = '{used: 1'b0, key: '0, id: '0};

endpackage

>>> sv/skpq_if.sv
// ----------------------------------------------------------------------------
// skpq channel interfaces
// valid/ready channels for request and response items
// ----------------------------------------------------------------------------
interface skpq_req_if
   import skpq_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [ID_BITS-1:0]  item_id;
   logic [KEY_BITS-1:0] key;

   modport source (output valid, command, item_id, key, input ready);
   modport sink   (input valid, command, item_id, key, output ready);
endinterface

interface skpq_rsp_if
   import skpq_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic                  popped_valid;
   logic [ID_BITS-1:0]    popped_id;
   logic [KEY_BITS-1:0]   popped_key;
   logic                  head_valid;
   logic [ID_BITS-1:0]    head_id;
   logic [KEY_BITS-1:0]   head_key;
   logic [COUNT_BITS-1:0] entry_count;

   modport source (output valid, status, popped_valid, popped_id, popped_key,
                   head_valid, head_id, head_key, entry_count, input ready);
   modport sink   (input valid, status, popped_valid, popped_id, popped_key,
                   head_valid, head_id, head_key, entry_count, output ready);
endinterface

>>> sv/skpq_cell.sv
// ----------------------------------------------------------------------------
// skpq_cell
// one slot of the sorted chain: compare, shift right on insert, left on remove
// ----------------------------------------------------------------------------
module skpq_cell
   import skpq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  op_type    op,
   input  entry_type left_entry,
   input  logic      left_take,
   input  logic      left_found,
   input  entry_type right_entry,
   output entry_type cur_entry,
   output logic      take,
   output logic      found
);

   logic                used_ff, used_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;

   // new key belongs here or further left
   assign take  = !used_ff || (key_ff > op.key);
   // first matching id at or left of this cell
   assign found = left_found || (op.match_en && used_ff && (id_ff == op.id));

   always_comb begin
      used_in = used_ff;
      key_in  = key_ff;
      id_in   = id_ff;
      if (op.do_insert && take && !left_take) begin
         used_in = 1'b1;
         key_in  = op.key;
         id_in   = op.id;
      end else if (op.do_insert && take) begin
         used_in = left_entry.used;
         key_in  = left_entry.key;
         id_in   = left_entry.id;
      end else if (op.do_remove && found) begin
         used_in = right_entry.used;
         key_in  = right_entry.key;
         id_in   = right_entry.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign cur_entry = '{used: used_ff, key: key_ff, id: id_ff};

endmodule

>>> sv/sorted_key_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_key_priority_queue
// up to DEPTH entries sorted by ascending key in a chain of compare cells
// ----------------------------------------------------------------------------
// throughput: one item per cycle while ready is high; every cell compares the broadcast key at once
// the result is registered and valid in the cycle after the item is accepted
// ready drops only while a result waits and the response side stalls
// reset clears the used bits, the entry count and the response valid
// ----------------------------------------------------------------------------
`include "sorted_key_priority_queue_macros.svh"

module sorted_key_priority_queue
   import skpq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   skpq_req_if.sink   req_ch,
   skpq_rsp_if.source rsp_ch
);

   // cell chain wiring
   entry_type  entries [DEPTH];
   logic       takes   [DEPTH];
   logic       founds  [DEPTH];
   logic [DEPTH-1:0] used_vec;

   op_type     op;
   cmd_type    cmd;
   logic       accept;
   logic       full;
   logic       empty;
   logic       id_hit;
   status_type status;
   logic       pop_ok;
   logic       ins_full;

   // response register and entry count
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  popped_valid_ff, popped_valid_in;
   logic [ID_BITS-1:0]    popped_id_ff, popped_id_in;
   logic [KEY_BITS-1:0]   popped_key_ff, popped_key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign cmd    = cmd_type'(req_ch.command);
   // a new item goes in when no result waits or the waiting one leaves now
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   assign full   = used_vec[DEPTH-1];
   assign empty  = !used_vec[0];
   // the found chain ends in the last cell: any match in the queue
   assign id_hit = founds[DEPTH-1];

   // accepted pop of a non-empty queue, accepted insert into a full one
   assign pop_ok   = accept && (cmd == CMD_POP) && !empty;
   assign ins_full = accept && (cmd == CMD_INSERT) && full;

   // broadcast to every cell
   always_comb begin
      op.do_insert = accept && (cmd == CMD_INSERT) && !full;
      op.do_remove = accept && (((cmd == CMD_DELETE) && id_hit) ||
                                ((cmd == CMD_POP) && !empty));
      op.match_en  = (cmd == CMD_DELETE);
      op.key       = req_ch.key;
      op.id        = req_ch.item_id;
   end

   // the chain itself: left neighbor feeds inserts, right neighbor feeds removes
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_take;
      logic      left_found;

      if (i == 0) begin : g_first
         assign left_entry = ENTRY_EMPTY;
         assign left_take  = 1'b0;
         // a pop shifts the whole chain toward the head
         assign left_found = (cmd == CMD_POP);
      end else begin : g_inner
         assign left_entry = entries[i-1];
         assign left_take  = takes[i-1];
         assign left_found = founds[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = ENTRY_EMPTY;
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      skpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .left_entry  (left_entry),
         .left_take   (left_take),
         .left_found  (left_found),
         .right_entry (right_entry),
         .cur_entry   (entries[i]),
         .take        (takes[i]),
         .found       (founds[i])
      );

      assign used_vec[i] = entries[i].used;
   end

   // status of the accepted item
   always_comb begin
      case (cmd)
         CMD_INSERT: status = full  ? ST_FULL      : ST_OK;
         CMD_DELETE: status = id_hit ? ST_OK       : ST_NOT_FOUND;
         CMD_POP:    status = empty ? ST_EMPTY     : ST_OK;
         default:    status = ST_OK;
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      popped_valid_in = popped_valid_ff;
      popped_id_in    = popped_id_ff;
      popped_key_in   = popped_key_ff;
      count_in        = count_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = status;
         popped_valid_in = (cmd == CMD_POP) && !empty;
         // head is taken before the chain shifts; zero unless it was popped
         popped_id_in    = popped_valid_in ? entries[0].id  : '0;
         popped_key_in   = popped_valid_in ? entries[0].key : '0;
      end
      if (op.do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (op.do_remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      popped_valid_ff <= popped_valid_in;
      popped_id_ff    <= popped_id_in;
      popped_key_ff   <= popped_key_in;
   end

   // the head cell only changes when an item is accepted, so it matches
   // the waiting result
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.popped_valid = popped_valid_ff;
   assign rsp_ch.popped_id    = popped_id_ff;
   assign rsp_ch.popped_key   = popped_key_ff;
   assign rsp_ch.head_valid   = entries[0].used;
   assign rsp_ch.head_id      = entries[0].used ? entries[0].id  : '0;
   assign rsp_ch.head_key     = entries[0].used ? entries[0].key : '0;
   assign rsp_ch.entry_count  = count_ff;

   // count tracks the used cells
   `SKPQ_ASSERT_IMP(a_count_matches, clock, reset, 1'b1, $countones(used_vec) == count_ff)
   // used cells always form a run from the head
   `SKPQ_ASSERT_IMP(a_used_prefix, clock, reset, 1'b1, (used_vec & (used_vec + 1'b1)) == '0)
   // a pop of a non-empty queue reports the popped entry
   `SKPQ_ASSERT_NXT(a_pop_reports, clock, reset, pop_ok, rsp_ch.valid && rsp_ch.popped_valid)
   // an insert into a full queue leaves it unchanged
   `SKPQ_ASSERT_NXT(a_full_reject, clock, reset, ins_full, $stable(used_vec))

endmodule
